@@ rtl/core/twled_pkg.sv @@
// Package for the two-wire LED driver master: item types, phase codes,
// command bytes and configuration constants.
// Used by every module in rtl/core; depends on nothing else.
package twled_pkg;

    // APB address width and register map.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_PHASE_TICKS = 3'd0;
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd4;

    // Command bytes and the mask of the bit that goes out first.
    localparam logic [7:0] CMD_SYSTEM  = 8'h48;
    localparam logic [7:0] CMD_KEYREAD = 8'h4F;
    localparam logic [7:0] MSB_MASK    = 8'h80;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Kind of input item.
    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_DISP = 2'd1,
        FUNC_SYS  = 2'd2,
        FUNC_KEY  = 2'd3
    } t_func;

    // Waveform phases, one-hot.
    typedef enum logic [14:0] {
        PH_IDLE    = 15'h0001,
        PH_START_A = 15'h0002,
        PH_START_B = 15'h0004,
        PH_START_C = 15'h0008,
        PH_WBIT_LO = 15'h0010,
        PH_WBIT_HI = 15'h0020,
        PH_WACK_LO = 15'h0040,
        PH_WACK_HI = 15'h0080,
        PH_RBIT_LO = 15'h0100,
        PH_RBIT_HI = 15'h0200,
        PH_RACK_LO = 15'h0400,
        PH_RACK_HI = 15'h0800,
        PH_STOP_A  = 15'h1000,
        PH_STOP_B  = 15'h2000,
        PH_STOP_C  = 15'h4000
    } t_phase;

    // One input item.
    typedef struct packed {
        t_func       func;
        logic [7:0]  addr_byte;
        logic [7:0]  data_byte;
        logic [2:0]  brightness;
        logic        seven_segment;
        logic        low_power;
        logic        display_on;
        logic        sda_in;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_drive;
        logic        busy_res;
        logic        rejected;
        logic        key_valid;
        logic [7:0]  key_code;
    } t_out_item;

    // A frame is in progress in every phase but idle; stray codes count as idle.
    function automatic logic ph_busy(input t_phase ph);
        logic b;
        case (ph)
            PH_START_A, PH_START_B, PH_START_C, PH_WBIT_LO, PH_WBIT_HI,
            PH_WACK_LO, PH_WACK_HI, PH_RBIT_LO, PH_RBIT_HI, PH_RACK_LO,
            PH_RACK_HI, PH_STOP_A, PH_STOP_B, PH_STOP_C: b = 1'b1;
            default: b = 1'b0;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/core/twled_cfg.sv @@
// APB register file of the two-wire LED driver master: holds phase_ticks.
// Depends on twled_pkg.
module twled_cfg
    import twled_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [7:0]         o_phase_ticks
);

    logic [7:0] r_phase_ticks;
    logic       wr_en;

    // A write lands in the access cycle.
    assign wr_en = psel && penable && pwrite && (paddr == ADDR_PHASE_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RESET;
        end else if (wr_en) begin
            r_phase_ticks <= pwdata[7:0];
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb begin
        prdata = 32'd0;
        if (paddr == ADDR_PHASE_TICKS) begin
            prdata = {24'd0, r_phase_ticks};
        end
    end

    assign pready        = 1'b1;
    assign o_phase_ticks = r_phase_ticks;

endmodule

@@ rtl/core/twled_core.sv @@
// Phase machine of the two-wire LED driver master: frame loading, tick
// counting, bit shifting and line decode for one item per cycle while i_en is high.
// Depends on twled_pkg.
module twled_core
    import twled_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_in_item   i_item,
    input  logic [7:0] i_phase_ticks,
    output t_out_item  o_result
);

    t_phase     r_phase,       n_phase;
    logic [3:0] r_bit_count,   n_bit_count;
    logic       r_byte_index,  n_byte_index;
    t_func      r_kind,        n_kind;
    logic [7:0] r_shift_reg,   n_shift_reg;
    logic [7:0] r_second_byte, n_second_byte;
    logic [7:0] r_tick_count,  n_tick_count;
    logic [7:0] r_key_reg,     n_key_reg;

    logic       busy;
    logic       rej;
    logic       key_done;
    logic [7:0] limit;
    logic [7:0] tick_inc;
    logic [3:0] bit_inc;

    assign busy     = ph_busy(r_phase);
    assign limit    = (i_phase_ticks == 8'd0) ? 8'd1 : i_phase_ticks;
    assign tick_inc = r_tick_count + 8'd1;
    assign bit_inc  = r_bit_count + 4'd1;

    // Next state for the item in the input register.
    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_byte_index  = r_byte_index;
        n_kind        = r_kind;
        n_shift_reg   = r_shift_reg;
        n_second_byte = r_second_byte;
        n_tick_count  = r_tick_count;
        n_key_reg     = r_key_reg;
        rej           = 1'b0;
        key_done      = 1'b0;

        if (i_item.func != FUNC_TICK) begin
            if (busy) begin
                rej = 1'b1;
            end else begin
                // Load a new frame.
                n_kind       = i_item.func;
                n_byte_index = 1'b0;
                n_bit_count  = 4'd0;
                n_tick_count = 8'd0;
                n_phase      = PH_START_A;
                case (i_item.func)
                    FUNC_DISP: begin
                        n_shift_reg   = i_item.addr_byte;
                        n_second_byte = i_item.data_byte;
                    end
                    FUNC_SYS: begin
                        n_shift_reg   = CMD_SYSTEM;
                        n_second_byte = {1'b0, i_item.brightness, i_item.seven_segment,
                                         i_item.low_power, 1'b0, i_item.display_on};
                    end
                    default: begin
                        n_shift_reg   = CMD_KEYREAD;
                        n_second_byte = 8'd0;
                    end
                endcase
            end
        end else if (busy) begin
            // Count ticks; step the waveform when the phase has run its time.
            n_tick_count = tick_inc;
            if (tick_inc >= limit) begin
                n_tick_count = 8'd0;
                case (r_phase)
                    PH_START_A: n_phase = PH_START_B;
                    PH_START_B: n_phase = PH_START_C;
                    PH_START_C: begin
                        n_bit_count = 4'd0;
                        n_phase     = PH_WBIT_LO;
                    end
                    PH_WBIT_LO: n_phase = PH_WBIT_HI;
                    PH_WBIT_HI: begin
                        n_shift_reg = {r_shift_reg[6:0], 1'b0};
                        n_bit_count = bit_inc;
                        n_phase     = (bit_inc >= BITS_PER_BYTE) ? PH_WACK_LO : PH_WBIT_LO;
                    end
                    PH_WACK_LO: n_phase = PH_WACK_HI;
                    PH_WACK_HI: begin
                        n_bit_count = 4'd0;
                        if (r_byte_index) begin
                            n_phase = PH_STOP_A;
                        end else if (r_kind == FUNC_KEY) begin
                            n_shift_reg = 8'd0;
                            n_phase     = PH_RBIT_LO;
                        end else begin
                            n_byte_index = 1'b1;
                            n_shift_reg  = r_second_byte;
                            n_phase      = PH_WBIT_LO;
                        end
                    end
                    PH_RBIT_LO: n_phase = PH_RBIT_HI;
                    PH_RBIT_HI: begin
                        n_shift_reg = {r_shift_reg[6:0], i_item.sda_in};
                        n_bit_count = bit_inc;
                        if (bit_inc >= BITS_PER_BYTE) begin
                            n_key_reg = {r_shift_reg[6:0], i_item.sda_in};
                            n_phase   = PH_RACK_LO;
                        end else begin
                            n_phase = PH_RBIT_LO;
                        end
                    end
                    PH_RACK_LO: n_phase = PH_RACK_HI;
                    PH_RACK_HI: n_phase = PH_STOP_A;
                    PH_STOP_A:  n_phase = PH_STOP_B;
                    PH_STOP_B:  n_phase = PH_STOP_C;
                    PH_STOP_C: begin
                        key_done = (r_kind == FUNC_KEY);
                        n_phase  = PH_IDLE;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
        end else begin
            n_phase = PH_IDLE;
        end
    end

    // Line levels decoded from the phase the item leaves behind.
    always_comb begin
        o_result.scl       = 1'b1;
        o_result.sda_out   = 1'b1;
        o_result.sda_drive = 1'b0;
        case (n_phase)
            PH_START_A: o_result.sda_drive = 1'b1;
            PH_START_B: begin
                o_result.sda_out   = 1'b0;
                o_result.sda_drive = 1'b1;
            end
            PH_START_C, PH_STOP_A, PH_RACK_LO: begin
                o_result.scl       = 1'b0;
                o_result.sda_out   = 1'b0;
                o_result.sda_drive = 1'b1;
            end
            PH_WBIT_LO: begin
                o_result.scl       = 1'b0;
                o_result.sda_out   = (n_shift_reg & MSB_MASK) != 8'd0;
                o_result.sda_drive = 1'b1;
            end
            PH_WBIT_HI: begin
                o_result.sda_out   = (n_shift_reg & MSB_MASK) != 8'd0;
                o_result.sda_drive = 1'b1;
            end
            PH_WACK_LO, PH_RBIT_LO: o_result.scl = 1'b0;
            PH_RACK_HI, PH_STOP_B: begin
                o_result.sda_out   = 1'b0;
                o_result.sda_drive = 1'b1;
            end
            PH_STOP_C: o_result.sda_drive = 1'b1;
            default: o_result.scl = 1'b1;
        endcase
        o_result.busy_res  = ph_busy(n_phase);
        o_result.rejected  = rej;
        o_result.key_valid = key_done;
        o_result.key_code  = n_key_reg;
    end

    // State advances only when the item moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= 4'd0;
            r_byte_index  <= 1'b0;
            r_kind        <= FUNC_TICK;
            r_shift_reg   <= 8'd0;
            r_second_byte <= 8'd0;
            r_tick_count  <= 8'd0;
            r_key_reg     <= 8'd0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_byte_index  <= n_byte_index;
            r_kind        <= n_kind;
            r_shift_reg   <= n_shift_reg;
            r_second_byte <= n_second_byte;
            r_tick_count  <= n_tick_count;
            r_key_reg     <= n_key_reg;
        end
    end

endmodule

@@ rtl/core/two_wire_led_driver_master.sv @@
// Two-wire LED driver master, top level: input register, phase machine and result register.
// Stages: only the input register and the result register.
// Throughput: one item per cycle unless a full result register is stalled.
// Reset is synchronous, active low: idle bus, phase_ticks back to 4, key code cleared.
// Depends on twled_pkg, twled_cfg and twled_core.
module two_wire_led_driver_master
    import twled_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic       in_accept;
    logic       out_load;
    logic [7:0] phase_ticks;
    t_out_item  result;

    // The item in the input register moves on whenever the result register frees up.
    assign out_load   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !out_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    twled_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_phase_ticks (phase_ticks)
    );

    twled_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (out_load),
        .i_item        (r_in_item),
        .i_phase_ticks (phase_ticks),
        .o_result      (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (out_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The input side only backs up behind a full, stalled result register.
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled while the result register could take an item");

    // A rejected command leaves the frame running.
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.rejected) |-> r_out_item.busy_res)
        else $error("rejected item reported with the bus idle");

    // A finished key read leaves the bus idle.
    a_key_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.key_valid) |-> !r_out_item.busy_res)
        else $error("key read completion reported while still busy");

    // A released data line always reads as high.
    a_release_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.sda_drive) |-> r_out_item.sda_out)
        else $error("data line released with a low level");

endmodule

@@ bench/two_wire_led_driver_master_checker.sv @@
// Checker for the two-wire LED driver master: watches the item channels and the
// APB port, predicts every result item and compares it with what the block returns.
// Depends on twled_pkg for the item types, phase codes and command bytes.
module two_wire_led_driver_master_checker
    import twled_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_in_item           i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_out_item          i_out_item,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output logic               o_frame_busy
);

    // Shadow copy of the bus master state and its one register.
    t_phase     bus_phase;
    logic [3:0] bits_done;
    logic       second_sent;
    t_func      frame_kind;
    logic [7:0] tx_shift;
    logic [7:0] tx_second;
    logic [7:0] tick_cnt;
    logic [7:0] key_byte;
    logic [7:0] ticks_per_phase;

    t_out_item  expected_levels[$];
    int         mismatches;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_frame_busy = 1'b0;
        mismatches   = 0;
    end

    // Applies one input item to the shadow state and returns the line levels after it.
    function automatic t_out_item bus_step(input t_in_item it);
        t_out_item  lv;
        logic       busy;
        logic       key_done;
        logic [7:0] limit;
        busy     = (bus_phase != PH_IDLE);
        key_done = 1'b0;
        limit    = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
        lv       = '0;

        if (it.func != FUNC_TICK) begin
            // A command is taken only while the bus is idle.
            if (busy) begin
                lv.rejected = 1'b1;
            end else begin
                frame_kind  = it.func;
                second_sent = 1'b0;
                bits_done   = 4'd0;
                tick_cnt    = 8'd0;
                case (it.func)
                    FUNC_DISP: begin
                        tx_shift  = it.addr_byte;
                        tx_second = it.data_byte;
                    end
                    FUNC_SYS: begin
                        tx_shift  = CMD_SYSTEM;
                        tx_second = {1'b0, it.brightness, it.seven_segment, it.low_power,
                                     1'b0, it.display_on};
                    end
                    default: begin
                        tx_shift  = CMD_KEYREAD;
                        tx_second = 8'd0;
                    end
                endcase
                bus_phase = PH_START_A;
            end
        end else if (busy) begin
            // A tick moves the waveform one phase once the phase time is used up.
            tick_cnt = tick_cnt + 8'd1;
            if (tick_cnt >= limit) begin
                tick_cnt = 8'd0;
                case (bus_phase)
                    PH_START_A: bus_phase = PH_START_B;
                    PH_START_B: bus_phase = PH_START_C;
                    PH_START_C: begin
                        bits_done = 4'd0;
                        bus_phase = PH_WBIT_LO;
                    end
                    PH_WBIT_LO: bus_phase = PH_WBIT_HI;
                    PH_WBIT_HI: begin
                        tx_shift  = {tx_shift[6:0], 1'b0};
                        bits_done = bits_done + 4'd1;
                        bus_phase = (bits_done >= BITS_PER_BYTE) ? PH_WACK_LO : PH_WBIT_LO;
                    end
                    PH_WACK_LO: bus_phase = PH_WACK_HI;
                    PH_WACK_HI: begin
                        bits_done = 4'd0;
                        if (second_sent) begin
                            bus_phase = PH_STOP_A;
                        end else if (frame_kind == FUNC_KEY) begin
                            tx_shift  = 8'd0;
                            bus_phase = PH_RBIT_LO;
                        end else begin
                            second_sent = 1'b1;
                            tx_shift    = tx_second;
                            bus_phase   = PH_WBIT_LO;
                        end
                    end
                    PH_RBIT_LO: bus_phase = PH_RBIT_HI;
                    PH_RBIT_HI: begin
                        tx_shift  = {tx_shift[6:0], it.sda_in};
                        bits_done = bits_done + 4'd1;
                        if (bits_done >= BITS_PER_BYTE) begin
                            key_byte  = tx_shift;
                            bus_phase = PH_RACK_LO;
                        end else begin
                            bus_phase = PH_RBIT_LO;
                        end
                    end
                    PH_RACK_LO: bus_phase = PH_RACK_HI;
                    PH_RACK_HI: bus_phase = PH_STOP_A;
                    PH_STOP_A:  bus_phase = PH_STOP_B;
                    PH_STOP_B:  bus_phase = PH_STOP_C;
                    PH_STOP_C: begin
                        key_done  = (frame_kind == FUNC_KEY);
                        bus_phase = PH_IDLE;
                    end
                    default: bus_phase = PH_IDLE;
                endcase
            end
        end else begin
            bus_phase = PH_IDLE;
        end

        // Line levels for the phase now entered; released data reads as high.
        lv.scl       = 1'b1;
        lv.sda_out   = 1'b1;
        lv.sda_drive = 1'b0;
        case (bus_phase)
            PH_START_A: lv.sda_drive = 1'b1;
            PH_START_B: begin
                lv.sda_out   = 1'b0;
                lv.sda_drive = 1'b1;
            end
            PH_START_C, PH_RACK_LO, PH_STOP_A: begin
                lv.scl       = 1'b0;
                lv.sda_out   = 1'b0;
                lv.sda_drive = 1'b1;
            end
            PH_WBIT_LO: begin
                lv.scl       = 1'b0;
                lv.sda_out   = tx_shift[7];
                lv.sda_drive = 1'b1;
            end
            PH_WBIT_HI: begin
                lv.sda_out   = tx_shift[7];
                lv.sda_drive = 1'b1;
            end
            PH_WACK_LO, PH_RBIT_LO: lv.scl = 1'b0;
            PH_RACK_HI, PH_STOP_B: begin
                lv.sda_out   = 1'b0;
                lv.sda_drive = 1'b1;
            end
            PH_STOP_C: lv.sda_drive = 1'b1;
            default: ;
        endcase
        lv.busy_res  = (bus_phase != PH_IDLE);
        lv.key_valid = key_done;
        lv.key_code  = key_byte;
        return lv;
    endfunction

    // Watch both channels and the register port on every rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            bus_phase       = PH_IDLE;
            bits_done       = 4'd0;
            second_sent     = 1'b0;
            frame_kind      = FUNC_TICK;
            tx_shift        = 8'd0;
            tx_second       = 8'd0;
            tick_cnt        = 8'd0;
            key_byte        = 8'd0;
            ticks_per_phase = PHASE_TICKS_RESET;
            expected_levels.delete();
        end else begin
            // Results are checked before new items are queued.
            if (i_out_valid && !i_out_stall) begin
                if (expected_levels.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10) begin
                        $display("unexpected result item: %p", i_out_item);
                    end
                end else begin
                    want = expected_levels.pop_front();
                    if (i_out_item.scl !== want.scl || i_out_item.sda_out !== want.sda_out ||
                        i_out_item.sda_drive !== want.sda_drive ||
                        i_out_item.busy_res !== want.busy_res ||
                        i_out_item.rejected !== want.rejected ||
                        i_out_item.key_valid !== want.key_valid ||
                        i_out_item.key_code !== want.key_code) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10) begin
                            $display("result mismatch: expected %p, got %p", want, i_out_item);
                        end
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == ADDR_PHASE_TICKS) begin
                ticks_per_phase = i_pwdata[7:0];
            end
            if (i_in_valid && !i_in_stall) begin
                expected_levels.push_back(bus_step(i_in_item));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_levels.size();
        o_frame_busy <= (bus_phase != PH_IDLE);
    end

endmodule

@@ bench/two_wire_led_driver_master_test.sv @@
// Top of the two-wire LED driver master bench: clock, reset, item and APB stimulus,
// and the final verdict. Depends on twled_pkg, the block and the checker module.
module two_wire_led_driver_master_test;
    import twled_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 130;
    localparam int SLOW_TICKS   = 260;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_item           in_item   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_item          out_item;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;

    int   fail_count;
    int   pending;
    logic frame_busy;
    int   cycle_count = 0;
    int   burst_left  = 0;
    int   stall_run   = 0;
    int   stall_mode  = 0;

    two_wire_led_driver_master DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    two_wire_led_driver_master_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_frame_busy (frame_busy)
    );

    // Clock with a period of four units.
    always #2 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The result side stalls in stretches of changing density, some with no stall at all.
    always @(negedge clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 4);
            stall_run  <= $urandom_range(16, 80);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= 1'($urandom_range(0, 1));
            3: out_stall <= ((stall_run % 5) < 2);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Builds a command item with the given fields.
    function automatic t_in_item make_cmd(input t_func f, input logic [7:0] a,
                                          input logic [7:0] d, input logic [2:0] br,
                                          input logic seg, input logic lp, input logic on);
        t_in_item it;
        it.func          = f;
        it.addr_byte     = a;
        it.data_byte     = d;
        it.brightness    = br;
        it.seven_segment = seg;
        it.low_power     = lp;
        it.display_on    = on;
        it.sda_in        = 1'b0;
        return it;
    endfunction

    // Random item; cmd_pct is the chance in percent of a command instead of a tick.
    function automatic t_in_item rand_item(input int cmd_pct);
        t_in_item it;
        it.func          = ($urandom_range(0, 99) < cmd_pct) ?
                           t_func'($urandom_range(1, 3)) : FUNC_TICK;
        it.addr_byte     = 8'($urandom_range(0, 255));
        it.data_byte     = 8'($urandom_range(0, 255));
        it.brightness    = 3'($urandom_range(0, 7));
        it.seven_segment = 1'($urandom_range(0, 1));
        it.low_power     = 1'($urandom_range(0, 1));
        it.display_on    = 1'($urandom_range(0, 1));
        it.sda_in        = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Tick item with the data line held low (0), high (1) or random (2).
    function automatic t_in_item tick_item(input int sda_mode);
        t_in_item it;
        it        = rand_item(0);
        it.sda_in = (sda_mode == 2) ? it.sda_in : (sda_mode == 1);
        return it;
    endfunction

    // Sends one item; items go out in bursts with random gaps between them.
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Ticks the bus until the current frame has ended.
    task automatic drain_frame(input int sda_mode);
        send_item(tick_item(sda_mode));
        while (frame_busy) send_item(tick_item(sda_mode));
    endtask

    // Stops sending and waits until every result item has come back.
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes phase_ticks through a setup and an access cycle.
    task automatic write_phase_ticks(input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PHASE_TICKS;
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        t_in_item   directed[7];
        int         key_sda[7];
        logic [7:0] plan[6];

        // Extreme bytes, both brightness ends and key reads with fixed and random data.
        directed[0] = make_cmd(FUNC_DISP, 8'hFF, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0);
        directed[1] = make_cmd(FUNC_DISP, 8'h00, 8'hFF, 3'd7, 1'b1, 1'b1, 1'b1);
        directed[2] = make_cmd(FUNC_SYS,  8'h00, 8'h00, 3'd0, 1'b1, 1'b1, 1'b1);
        directed[3] = make_cmd(FUNC_SYS,  8'hFF, 8'hFF, 3'd7, 1'b0, 1'b0, 1'b0);
        directed[4] = make_cmd(FUNC_KEY,  8'h00, 8'h00, 3'd0, 1'b0, 1'b0, 1'b0);
        directed[5] = make_cmd(FUNC_KEY,  8'hFF, 8'hFF, 3'd7, 1'b1, 1'b1, 1'b1);
        directed[6] = make_cmd(FUNC_KEY,  8'h5A, 8'hA5, 3'd3, 1'b0, 1'b1, 1'b0);
        key_sda     = '{2, 2, 2, 2, 1, 0, 2};
        plan        = '{8'd2, 8'd255, 8'd3, 8'd0, 8'd1, 8'd4};

        // Reset is held low, then released on a falling clock edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Ticks on an idle bus change nothing.
        repeat (2) send_item(tick_item(2));
        wait_quiet();
        write_phase_ticks(8'd1);

        // Each directed frame is followed at once by a command that must be rejected.
        foreach (directed[k]) begin
            send_item(directed[k]);
            send_item(make_cmd(t_func'(1 + k % 3), 8'hC3, 8'h3C, 3'd5, 1'b1, 1'b0, 1'b1));
            drain_frame(key_sda[k]);
        end

        // Random frames under a series of phase times, the extremes among them.
        foreach (plan[p]) begin
            drain_frame(2);
            wait_quiet();
            write_phase_ticks(plan[p]);
            if (plan[p] == 8'd255) begin
                // The slowest setting gets one frame, ticked past its first phase step;
                // the rest of that frame runs at the fastest setting.
                send_item(rand_item(100));
                repeat (SLOW_TICKS) send_item(tick_item(2));
                wait_quiet();
                write_phase_ticks(8'd1);
            end else begin
                for (int i = 0; i < RANDOM_ITEMS; i++) begin
                    if (p == 0 && i == RANDOM_ITEMS / 2) begin
                        wait_quiet();
                    end
                    send_item(rand_item(frame_busy ? 5 : 70));
                end
            end
        end

        // Let every result come back, then give the verdict.
        wait_quiet();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
